// ===== design/mme_pkg.sv =====
// ----------------------------------------------------------------------------
// mme_pkg: shared types and constants for the matrix multiply engine
// Holds the store geometry, the request and result records, the command and
// register codes, and the controller state type.
// ----------------------------------------------------------------------------
package mme_pkg;

	// Largest matrix dimension and the geometry of the element stores.
	localparam int MAX_DIM     = 16;
	localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int DIM_W       = $clog2(MAX_DIM + 1);

	// Exact sum of MAX_DIM products of two Q16.16 values, plus a sign bit.
	localparam int PROD_W = 64;
	localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;

	// Fixed field widths of the interface.
	localparam int CMD_W  = 2;
	localparam int IDX_W  = 8;
	localparam int ELEM_W = 32;
	localparam int POS_W  = 4;
	localparam int CFG_W  = 5;
	localparam int REG_W  = 2;

	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	// Request commands.
	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_A  = 2'd0,
		CMD_LOAD_B  = 2'd1,
		CMD_COMPUTE = 2'd2
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic [REG_W-1:0] {
		REG_ROWS  = 2'd0,
		REG_INNER = 2'd1,
		REG_COLS  = 2'd2
	} reg_idx_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// Input request record.
	typedef struct packed {
		logic        [CMD_W-1:0]  command;
		logic        [IDX_W-1:0]  elem_index;
		logic signed [ELEM_W-1:0] elem_value;
		logic        [POS_W-1:0]  want_row;
		logic        [POS_W-1:0]  want_col;
	} in_item_t;

	// Result record.
	typedef struct packed {
		logic signed [PROD_W-1:0] dot_value;
		logic        [POS_W-1:0]  out_row;
		logic        [POS_W-1:0]  out_col;
		logic                     saturated;
	} out_item_t;

	// Effective dimension: zero acts as one, values above MAX_DIM clip.
	function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > MAX_DIM) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

endpackage

// ===== design/matrix_multiply_engine.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_engine: dense matrix product, one element per request
// Load requests write elements of A or B into two synchronous stores. A
// compute request walks one row of A and one column of B through a pipelined
// multiply-accumulate and returns the saturated Q32.32 dot product.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  in        input      in_valid / in_ready   in_data (in_item_t)
//  out       output     out_valid / out_ready out_data (out_item_t)
//  cfg       input      cfg_we                cfg_index, cfg_data
//
//  A load request is written to its store at acceptance.
//  A compute request issues inner store reads through the A and B read ports,
//  one per cycle, then passes a multiply stage, an accumulate stage and the
//  saturating output register.
//  The next request can be taken in the cycle after the result is loaded.
//  Requests are taken only while the controller is idle; a waiting result does
//  not block new requests, but the next result waits until it is taken.
//  Reset clears the controller and sets every dimension register to 16; the
//  store contents are undefined until written.
// ----------------------------------------------------------------------------
module matrix_multiply_engine
	import mme_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	input  logic             cfg_we,
	input  logic [REG_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	// Element stores.
	logic [ELEM_W-1:0] a_mem [STORE_DEPTH];
	logic [ELEM_W-1:0] b_mem [STORE_DEPTH];

	logic [CFG_W-1:0] rows_q, inner_q, cols_q;
	state_t           state_q, state_d;

	logic [ADDR_W-1:0] a_addr_q, b_addr_q;
	logic [DIM_W-1:0]  k_q, ni_q, nc_q;
	logic [POS_W-1:0]  row_q, col_q;

	logic                     issue_s1, last_s1;
	logic signed [ELEM_W-1:0] rd_a_s1, rd_b_s1;
	logic                     valid_s2, last_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;

	logic      out_valid_q;
	out_item_t out_q;

	logic              accept, start, issue, last_issue, out_load, in_range;
	logic              wr_ok;
	logic [ADDR_W-1:0] wr_addr, a_base;
	logic [DIM_W-1:0]  nr_eff, ni_eff, nc_eff;
	logic              acc_fits;

	// Request decode and dimension clipping.
	always_comb begin
		nr_eff   = eff_dim(rows_q);
		ni_eff   = eff_dim(inner_q);
		nc_eff   = eff_dim(cols_q);
		accept   = in_valid && in_ready;
		in_range = (32'(in_data.want_row) < 32'(nr_eff)) &&
			(32'(in_data.want_col) < 32'(nc_eff));
		start    = accept && (in_data.command == CMD_COMPUTE) && in_range;
		wr_ok    = 32'(in_data.elem_index) < STORE_DEPTH;
		wr_addr  = ADDR_W'(in_data.elem_index);
		a_base   = ADDR_W'(32'(in_data.want_row) * 32'(ni_eff));
		last_issue = (k_q == ni_q - DIM_W'(1));
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= CFG_RESET;
			inner_q <= CFG_RESET;
			cols_q  <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROWS:  rows_q  <= cfg_data;
				REG_INNER: inner_q <= cfg_data;
				REG_COLS:  cols_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Store writes and registered reads.
	always_ff @(posedge clk) begin
		if (accept && wr_ok && (in_data.command == CMD_LOAD_A)) begin
			a_mem[wr_addr] <= in_data.elem_value;
		end
		if (accept && wr_ok && (in_data.command == CMD_LOAD_B)) begin
			b_mem[wr_addr] <= in_data.elem_value;
		end
		rd_a_s1 <= a_mem[a_addr_q];
		rd_b_s1 <= b_mem[b_addr_q];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (last_issue) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (valid_s2 && last_s2) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Controller outputs.
	always_comb begin
		in_ready = 1'b0;
		issue    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_RUN:    issue    = 1'b1;
			ST_DRAIN:  ;
			ST_FINISH: out_load = !out_valid_q || out_ready;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Address walk: A steps by one, B steps by the column count.
	always_ff @(posedge clk) begin
		if (start) begin
			a_addr_q <= a_base;
			b_addr_q <= ADDR_W'(in_data.want_col);
			k_q      <= '0;
			ni_q     <= ni_eff;
			nc_q     <= nc_eff;
			row_q    <= in_data.want_row;
			col_q    <= in_data.want_col;
		end else if (issue) begin
			a_addr_q <= a_addr_q + ADDR_W'(1);
			b_addr_q <= ADDR_W'(b_addr_q + ADDR_W'(nc_q));
			k_q      <= k_q + DIM_W'(1);
		end
	end

	// Pipeline valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
			last_s1  <= 1'b0;
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
		end else begin
			issue_s1 <= issue;
			last_s1  <= issue && last_issue;
			valid_s2 <= issue_s1;
			last_s2  <= last_s1;
		end
	end

	// Multiply stage and exact accumulation.
	always_ff @(posedge clk) begin
		prod_s2 <= rd_a_s1 * rd_b_s1;
		if (start) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// The sum fits when all bits above the 64-bit sign bit match it.
	always_comb begin
		acc_fits = (acc_q[ACC_W-1:PROD_W-1] == '0) || (acc_q[ACC_W-1:PROD_W-1] == '1);
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.out_row   <= row_q;
			out_q.out_col   <= col_q;
			out_q.saturated <= !acc_fits;
			if (acc_fits) begin
				out_q.dot_value <= acc_q[PROD_W-1:0];
			end else if (acc_q[ACC_W-1]) begin
				out_q.dot_value <= {1'b1, {(PROD_W-1){1'b0}}};
			end else begin
				out_q.dot_value <= {1'b0, {(PROD_W-1){1'b1}}};
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Checks on the controller and the pipeline.
	a_no_work_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> state_q != ST_IDLE)
		else $error("product stage active while idle");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> state_q == ST_FINISH && (!out_valid_q || out_ready))
		else $error("result loaded outside the finish step");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> k_q < ni_q)
		else $error("inner index ran past the inner size");

	a_hold_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINISH && out_valid_q && !out_ready |=> state_q == ST_FINISH)
		else $error("finished result overwrote a waiting one");

	a_drain_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN && valid_s2 && last_s2 |=> state_q == ST_FINISH)
		else $error("drain did not end on the last product");

endmodule
